// File: hw/rtl/hkrf_pkg.sv
// hkrf_pkg: shared types and constants of the HID key remap filter.
// Used by the interfaces, the remap cell and the top level. No dependencies.
package hkrf_pkg;

	localparam int unsigned KEY_SLOT_COUNT = 6;
	localparam int unsigned SLOTS_W        = 8 * KEY_SLOT_COUNT;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 8;

	localparam logic [7:0] REPORT_ID_KEYS = 8'd1;
	localparam logic [7:0] MIN_REPORT_LEN = 8'd9;
	localparam logic [7:0] NULL_CODE_RST  = 8'd255;

	typedef enum logic {
		OPC_WRITE  = 1'b0,
		OPC_REPORT = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_COUNT = 2'd0,
		CFG_NULL_CODE = 2'd1
	} cfg_idx_t;

	// One mapping table entry.
	typedef struct packed {
		logic [7:0] in_mod;
		logic [7:0] in_key;
		logic [7:0] out_mod;
		logic [7:0] out_key;
	} entry_t;

	// Report payload handed from cell to cell.
	typedef struct packed {
		logic               live;
		logic [7:0]         modifier;
		logic [SLOTS_W-1:0] slots;
		logic               remapped;
	} token_t;

endpackage

// File: hw/rtl/hkrf_ifs.sv
// hkrf_ifs: valid/ready channel interfaces of the HID key remap filter.
// Depends on hkrf_pkg.
interface hkrf_item_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [3:0]                       entry_index;
	logic [7:0]                       entry_in_mod;
	logic [7:0]                       entry_in_key;
	logic [7:0]                       entry_out_mod;
	logic [7:0]                       entry_out_key;
	logic [7:0]                       report_id;
	logic [7:0]                       report_length;
	logic [7:0]                       modifier;
	logic [hkrf_pkg::SLOTS_W-1:0]     key_slots;

	modport source (output valid, opcode, entry_index, entry_in_mod, entry_in_key,
		entry_out_mod, entry_out_key, report_id, report_length, modifier, key_slots,
		input ready);
	modport sink (input valid, opcode, entry_index, entry_in_mod, entry_in_key,
		entry_out_mod, entry_out_key, report_id, report_length, modifier, key_slots,
		output ready);
endinterface

interface hkrf_result_if;
	logic                             valid;
	logic                             ready;
	logic [7:0]                       modifier_out;
	logic [hkrf_pkg::SLOTS_W-1:0]     key_slots_out;
	logic                             remapped;

	modport source (output valid, modifier_out, key_slots_out, remapped, input ready);
	modport sink (input valid, modifier_out, key_slots_out, remapped, output ready);
endinterface

interface hkrf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hkrf_pkg::CFG_IDX_W-1:0]     index;
	logic [hkrf_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/hkrf_cell.sv
// hkrf_cell: one link of the remap chain; holds one table entry and
// tries it on the report passing by. Depends on hkrf_pkg.
module hkrf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  hkrf_pkg::entry_t    wr_entry,
	input  logic                active,
	input  logic [7:0]          null_code,
	input  logic                adv,
	input  logic                tok_valid,
	input  hkrf_pkg::token_t    tok,
	output logic                tok_valid_q,
	output hkrf_pkg::token_t    tok_q
);

	hkrf_pkg::entry_t entry_q;
	hkrf_pkg::token_t nxt;
	logic             qual;
	logic             hit;
	logic [2:0]       hit_slot;

	// Entry store; contents undefined until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end
	end

	assign qual = (entry_q.in_mod == null_code) ||
		((tok.modifier & entry_q.in_mod) == entry_q.in_mod);

	// Lowest matching slot wins.
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = hkrf_pkg::KEY_SLOT_COUNT - 1; s >= 0; s--) begin
			if (tok.slots[s*8 +: 8] == entry_q.in_key) begin
				hit      = 1'b1;
				hit_slot = 3'(s);
			end
		end
	end

	always_comb begin
		nxt = tok;
		if (tok.live && !tok.remapped && active && qual && hit) begin
			nxt.slots[hit_slot*8 +: 8] = entry_q.out_key;
			if (entry_q.out_mod != null_code) begin
				nxt.modifier = entry_q.out_mod;
			end
			nxt.remapped = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (adv) begin
			tok_valid_q <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
		end
	end

endmodule

// File: hw/rtl/hid_key_remap_filter_unit.sv
// hid_key_remap_filter_unit: top level of the HID key remap filter.
// Depends on hkrf_pkg, hkrf_ifs and hkrf_cell.
//
// Usage:
//   item   - input channel. opcode OPC_WRITE loads table entry entry_index
//            (ignored from MAX_MAPPINGS up) and gives no result. OPC_REPORT
//            sends a boot report through the remap chain.
//   result - one item per report: modifier, six key slots, remapped flag.
//   cfg    - register writes (map_count, null_code), always ready; write
//            only while the block is idle.
// Timing: a report walks a row of MAX_MAPPINGS cells, one cell per cycle
//   while the chain is not frozen, each cell holding one table entry, and
//   then enters the result register. One report is in the chain at a time,
//   so no item is taken until it leaves the last cell; writes at one per
//   cycle whenever no report is in the chain.
// Reset: clears map_count to 0 (pass-through), null_code to 255, empties
//   the chain and the output register. Table entries read as garbage until
//   written.
// Stall: the result register holds while ready is low; a report that
//   reaches the end of the chain then freezes the whole chain.
module hid_key_remap_filter_unit #(
	parameter int unsigned MAX_MAPPINGS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	hkrf_item_if.sink       item,
	hkrf_result_if.source   result,
	hkrf_cfg_if.sink        cfg
);

	// Configuration registers.
	logic [4:0] map_count_q;
	logic [7:0] null_code_q;

	// Chain control.
	logic busy_q;
	logic adv;
	logic item_acc;
	logic rpt_acc;
	logic wr_acc;

	// Result register.
	logic                         out_valid_q;
	logic [7:0]                   out_mod_q;
	logic [hkrf_pkg::SLOTS_W-1:0] out_slots_q;
	logic                         out_remap_q;

	// Token links: index e feeds cell e, index MAX_MAPPINGS leaves the chain.
	logic             tok_valid [MAX_MAPPINGS+1];
	hkrf_pkg::token_t tok       [MAX_MAPPINGS+1];
	logic [MAX_MAPPINGS-1:0] cell_valid;

	hkrf_pkg::entry_t wr_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_count_q <= '0;
			null_code_q <= hkrf_pkg::NULL_CODE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hkrf_pkg::CFG_MAP_COUNT: map_count_q <= cfg.data[4:0];
				hkrf_pkg::CFG_NULL_CODE: null_code_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Take items only while no report is in flight.
	assign item.ready = !busy_q;
	assign item_acc   = item.valid && item.ready;
	assign rpt_acc    = item_acc && (item.opcode == hkrf_pkg::OPC_REPORT);
	assign wr_acc     = item_acc && (item.opcode == hkrf_pkg::OPC_WRITE);

	assign wr_entry.in_mod  = item.entry_in_mod;
	assign wr_entry.in_key  = item.entry_in_key;
	assign wr_entry.out_mod = item.entry_out_mod;
	assign wr_entry.out_key = item.entry_out_key;

	// Head of the chain: mark the report live only if it is a keys report
	// long enough and remapping is enabled.
	assign tok_valid[0]    = rpt_acc;
	assign tok[0].live     = (item.report_id == hkrf_pkg::REPORT_ID_KEYS) &&
		(item.report_length >= hkrf_pkg::MIN_REPORT_LEN) && (map_count_q != 5'd0);
	assign tok[0].modifier = item.modifier;
	assign tok[0].slots    = item.key_slots;
	assign tok[0].remapped = 1'b0;

	// Freeze the chain while a finished report waits on a full result register.
	assign adv = !(tok_valid[MAX_MAPPINGS] && out_valid_q && !result.ready);

	for (genvar e = 0; e < MAX_MAPPINGS; e++) begin : g_cell
		logic wr_hit;
		logic active;

		// Cell e is in use when e < map_count; saturation is implied since e < MAX.
		assign active = 32'(map_count_q) > 32'(e);
		assign wr_hit = wr_acc && (32'(item.entry_index) == 32'(e));

		hkrf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_hit),
			.wr_entry    (wr_entry),
			.active      (active),
			.null_code   (null_code_q),
			.adv         (adv),
			.tok_valid   (tok_valid[e]),
			.tok         (tok[e]),
			.tok_valid_q (tok_valid[e+1]),
			.tok_q       (tok[e+1])
		);

		assign cell_valid[e] = tok_valid[e+1];
	end

	// Busy from acceptance until the report leaves the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (rpt_acc) begin
			busy_q <= 1'b1;
		end else if (tok_valid[MAX_MAPPINGS] && adv) begin
			busy_q <= 1'b0;
		end
	end

	// Result register: load from the chain end, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_valid[MAX_MAPPINGS] && adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid[MAX_MAPPINGS] && adv) begin
			out_mod_q   <= tok[MAX_MAPPINGS].modifier;
			out_slots_q <= tok[MAX_MAPPINGS].slots;
			out_remap_q <= tok[MAX_MAPPINGS].remapped;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.modifier_out  = out_mod_q;
	assign result.key_slots_out = out_slots_q;
	assign result.remapped      = out_remap_q;

	// At most one report in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid))
		else $error("more than one report in the remap chain");

	// Busy tracks chain occupancy.
	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (|cell_valid))
		else $error("busy flag disagrees with chain contents");

	// An accepted report enters the first cell.
	a_report_enters: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_acc |=> tok_valid[1] && busy_q)
		else $error("accepted report did not enter the chain");

	// A new result comes only from the chain end.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok_valid[MAX_MAPPINGS]))
		else $error("result appeared without a report leaving the chain");

	// Remapping never happens with the table disabled.
	a_remap_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_remap_q |-> map_count_q != 5'd0)
		else $error("remapped result with map_count zero");

endmodule
